/* rtl/i2cmbs_pkg.sv */
// Shared types and constants for the I2C master byte sequencer.
// No dependencies; imported by the step logic, the top level and the checker.
`timescale 1ns / 1ps

package i2cmbs_pkg;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    localparam int BitsPerByte  = 8;
    localparam int MsbPos       = 7;
    localparam int PhasesPerBit = 2;

    localparam logic [4:0] START_PHASES = 5'd2;
    localparam logic [4:0] STOP_PHASES  = 5'd3;
    localparam logic [4:0] BIT_PHASES   = 5'(BitsPerByte * PhasesPerBit);
    localparam logic [4:0] BYTE_PHASES  = 5'((BitsPerByte + 1) * PhasesPerBit);

    // Sequencer state, one copy held in the top level.
    typedef struct packed {
        logic       scl;
        logic       sda;
        op_t        op;
        logic [4:0] phase;
        logic [7:0] tick;
        logic [7:0] shift;
        logic       ack_to_send;
        logic       ack_flag;
    } seq_state_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic       nack_seen;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_level;
    } seq_result_t;

endpackage

/* rtl/i2cmbs_step.sv */
// Next-state logic of the I2C sequencer: one request in, the following state out.
// Depends on i2cmbs_pkg.
`timescale 1ns / 1ps

module i2cmbs_step (
    input  i2cmbs_pkg::seq_state_t cur,
    input  logic [7:0]             ticks_per_phase,
    input  logic [2:0]             operation,
    input  logic [7:0]             data_byte,
    input  logic                   send_ack,
    input  logic                   sda_in,
    output i2cmbs_pkg::seq_state_t nxt,
    output logic                   done
);
    import i2cmbs_pkg::*;

    // Line levels {scl, sda} on entering phase p of a command.
    function automatic logic [1:0] phase_lines(input op_t op, input logic [4:0] p,
                                               input logic [7:0] shift, input logic ack,
                                               input logic [1:0] keep);
        logic [1:0] lines;
        begin
            lines = keep;
            case (op)
                OP_START: lines = {1'b1, (p == 5'd0)};
                OP_STOP:  lines = {(p != 5'd0), (p == 5'd2)};
                OP_WRITE: lines = {p[0], (p < BIT_PHASES) ? shift[MsbPos] : 1'b1};
                OP_READ:  lines = {p[0], (p < BIT_PHASES) ? 1'b1 : ~ack};
                default:  lines = keep;
            endcase
            return lines;
        end
    endfunction

    logic       busy;
    logic [7:0] limit;
    logic [7:0] tick_inc;
    logic [4:0] phase_inc;
    logic [4:0] total;
    logic [7:0] shift_fin;
    logic       ack_fin;
    op_t        new_op;

    always_comb begin
        busy      = (cur.op != OP_TICK);
        limit     = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
        tick_inc  = cur.tick + 8'd1;
        phase_inc = cur.phase + 5'd1;
        new_op    = op_t'(operation);

        case (cur.op)
            OP_START: total = START_PHASES;
            OP_STOP:  total = STOP_PHASES;
            default:  total = BYTE_PHASES;
        endcase

        // Work at the end of a high phase: rotate, shift in, or take the ack.
        shift_fin = cur.shift;
        ack_fin   = cur.ack_flag;
        if (cur.phase[0]) begin
            if (cur.op == OP_WRITE) begin
                if (cur.phase < BIT_PHASES) begin
                    shift_fin = {cur.shift[MsbPos-1:0], cur.shift[MsbPos]};
                end else begin
                    ack_fin = sda_in;
                end
            end else if (cur.op == OP_READ && cur.phase < BIT_PHASES) begin
                shift_fin = {cur.shift[MsbPos-1:0], sda_in};
            end
        end

        nxt  = cur;
        done = 1'b0;

        if (operation == OP_TICK) begin
            if (busy) begin
                if (tick_inc >= limit) begin
                    nxt.tick     = 8'd0;
                    nxt.shift    = shift_fin;
                    nxt.ack_flag = ack_fin;
                    if (phase_inc >= total) begin
                        // Sequence complete: park the lines after a start or a byte and go idle.
                        if (cur.op == OP_START) begin
                            nxt.scl = 1'b0;
                            nxt.sda = 1'b0;
                        end else if (cur.op == OP_WRITE || cur.op == OP_READ) begin
                            nxt.scl = 1'b0;
                            nxt.sda = 1'b1;
                        end
                        nxt.op    = OP_TICK;
                        nxt.phase = 5'd0;
                        done      = 1'b1;
                    end else begin
                        nxt.phase = phase_inc;
                        {nxt.scl, nxt.sda} = phase_lines(cur.op, phase_inc, shift_fin,
                                                         cur.ack_to_send, {cur.scl, cur.sda});
                    end
                end else begin
                    nxt.tick = tick_inc;
                end
            end
        end else if (operation <= OP_READ && !busy) begin
            nxt.op    = new_op;
            nxt.phase = 5'd0;
            nxt.tick  = 8'd0;
            if (operation == OP_WRITE) begin
                nxt.shift = data_byte;
            end
            if (operation == OP_READ) begin
                nxt.ack_to_send = send_ack;
            end
            {nxt.scl, nxt.sda} = phase_lines(new_op, 5'd0, nxt.shift, nxt.ack_to_send,
                                             {cur.scl, cur.sda});
        end
    end

endmodule

/* rtl/i2c_master_byte_sequencer_unit.sv */
// I2C master byte sequencer, top level: handshake, state and result registers.
// Depends on i2cmbs_pkg and i2cmbs_step.
`timescale 1ns / 1ps

// Usage: send one request per command (start, stop, write byte, read byte) and
// one tick request per bus time step carrying the sampled SDA level; every
// request returns exactly one result with the SCL/SDA levels to drive, busy,
// a done pulse on the tick that ends a command, the shift register (read byte)
// and the write acknowledge sample. Each bus phase lasts ticks_per_phase ticks
// (zero counts as one). Commands given while busy and unknown operation codes
// leave the state alone and just report it. Throughput is one request per
// clock while results are taken, each result showing in the cycle after its
// request is accepted: the state update is one pass of combinational step
// logic between the state and result registers; s_tready drops only while a
// result sits untaken. Write ticks_per_phase only while no command is running.

module i2c_master_byte_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: ticks_per_phase
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] send_ack, [9] sda_in, zero pad
    input  logic [2:0]  s_tuser,   // [2:0] operation
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] scl_level, [1] sda_release, [2] busy_res,
                                   // [3] done_res, [11:4] read_byte, [12] nack_seen
);
    import i2cmbs_pkg::*;

    logic [7:0]  tpp_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic        done;
    logic        m_tvalid_reg;
    seq_result_t result_reg;
    seq_result_t result_next;
    logic        accept;

    // Take a new request whenever the result register is empty or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpp_reg <= 8'd1;
        end else if (cfg_wr_en) begin
            tpp_reg <= cfg_wr_data;
        end
    end

    i2cmbs_step u_step (
        .cur             (state_reg),
        .ticks_per_phase (tpp_reg),
        .operation       (s_tuser),
        .data_byte       (s_tdata[7:0]),
        .send_ack        (s_tdata[8]),
        .sda_in          (s_tdata[9]),
        .nxt             (state_next),
        .done            (done)
    );

    // The result reflects the state after the request.
    always_comb begin
        result_next.scl_level   = state_next.scl;
        result_next.sda_release = state_next.sda;
        result_next.busy_res    = (state_next.op != OP_TICK);
        result_next.done_res    = done;
        result_next.read_byte   = state_next.shift;
        result_next.nack_seen   = state_next.ack_flag;
    end

    // Advance the state only on an accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.scl         <= 1'b0;
            state_reg.sda         <= 1'b1;
            state_reg.op          <= OP_TICK;
            state_reg.phase       <= 5'd0;
            state_reg.tick        <= 8'd0;
            state_reg.shift       <= 8'd0;
            state_reg.ack_to_send <= 1'b0;
            state_reg.ack_flag    <= 1'b0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Result register: load on accept, hold while stalled, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, result_reg};

endmodule

/* rtl/i2cmbs_checker.sv */
// Port-level checker for the I2C master byte sequencer, with its bind.
// Depends on i2cmbs_pkg and i2c_master_byte_sequencer_unit.
`timescale 1ns / 1ps

module i2cmbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import i2cmbs_pkg::*;

    seq_result_t res;
    assign res = seq_result_t'(m_tdata[12:0]);

    // A done pulse always comes with the sequencer gone idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.done_res |-> !res.busy_res)
        else $error("done result while still busy");

    // Backpressure only while a result waits.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("request stalled with no pending result");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Every accepted request yields a result on the next cycle.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request produced no result");

endmodule

bind i2c_master_byte_sequencer_unit i2cmbs_checker u_i2cmbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/i2c_master_byte_sequencer_unit_tb.sv */
// Self-checking testbench for i2c_master_byte_sequencer_unit: drives command and tick requests,
// predicts each result from its own copy of the sequencer state and checks every result.
// Depends on i2cmbs_pkg and the i2c_master_byte_sequencer_unit RTL.
`timescale 1ns / 1ps

module i2c_master_byte_sequencer_unit_tb;
    import i2cmbs_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // Operation codes the block does not define; they must leave the state alone.
    localparam logic [2:0] OP_BAD_LO = 3'd5;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    // Sequencer predictor and result scoreboard.
    class sequencer_scoreboard;
        logic [7:0]  phase_ticks;
        logic        scl;
        logic        sda;
        op_t         cur_op;
        logic [4:0]  phase;
        logic [7:0]  tick_cnt;
        logic [7:0]  shifter;
        logic        ack_to_send;
        logic        ack_flag;
        seq_result_t expected_results[$];
        int          mismatches;

        function new();
            phase_ticks = 8'd1;
            scl         = 1'b0;
            sda         = 1'b1;
            cur_op      = OP_TICK;
            phase       = '0;
            tick_cnt    = '0;
            shifter     = '0;
            ack_to_send = 1'b0;
            ack_flag    = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_phase_ticks(logic [7:0] value);
            phase_ticks = value;
        endfunction

        function bit busy();
            return cur_op != OP_TICK;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function logic [4:0] phase_total();
            if (cur_op == OP_START) return START_PHASES;
            if (cur_op == OP_STOP) return STOP_PHASES;
            return BYTE_PHASES;
        endfunction

        // Set the lines for the phase just entered.
        function void drive_phase();
            case (cur_op)
                OP_START: begin
                    scl = 1'b1;
                    sda = (phase == 5'd0);
                end
                OP_STOP: begin
                    scl = (phase != 5'd0);
                    sda = (phase == 5'd2);
                end
                OP_WRITE: begin
                    scl = phase[0];
                    sda = (phase < BIT_PHASES) ? shifter[7] : 1'b1;
                end
                OP_READ: begin
                    scl = phase[0];
                    sda = (phase < BIT_PHASES) ? 1'b1 : ~ack_to_send;
                end
                default: ;
            endcase
        endfunction

        // Last tick of a phase: sample or rotate at the end of every SCL-high phase.
        function void close_phase(logic sda_in);
            if (!phase[0]) return;
            if (cur_op == OP_WRITE) begin
                if (phase < BIT_PHASES) shifter = {shifter[6:0], shifter[7]};
                else ack_flag = sda_in;
            end else if (cur_op == OP_READ) begin
                if (phase < BIT_PHASES) shifter = {shifter[6:0], sda_in};
            end
        endfunction

        // Advance the predicted state by one accepted request and queue its result.
        // Returns 1 when the request had any effect on the sequencer.
        function bit note_request(logic [2:0] op, logic [7:0] data, logic ack, logic sda_in);
            seq_result_t want;
            logic        done_now;
            logic [7:0]  limit;
            bit          effect;
            done_now = 1'b0;
            effect   = 1'b0;
            if (op == OP_TICK) begin
                if (busy()) begin
                    effect   = 1'b1;
                    limit    = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
                    tick_cnt = tick_cnt + 8'd1;
                    if (tick_cnt >= limit) begin
                        tick_cnt = '0;
                        close_phase(sda_in);
                        phase = phase + 5'd1;
                        if (phase >= phase_total()) begin
                            if (cur_op == OP_START) begin
                                scl = 1'b0;
                                sda = 1'b0;
                            end else if (cur_op == OP_WRITE || cur_op == OP_READ) begin
                                scl = 1'b0;
                                sda = 1'b1;
                            end
                            cur_op   = OP_TICK;
                            phase    = '0;
                            done_now = 1'b1;
                        end else begin
                            drive_phase();
                        end
                    end
                end
            end else if (op <= OP_READ && !busy()) begin
                effect   = 1'b1;
                cur_op   = op_t'(op);
                phase    = '0;
                tick_cnt = '0;
                if (cur_op == OP_WRITE) shifter = data;
                if (cur_op == OP_READ) ack_to_send = ack;
                drive_phase();
            end
            want.scl_level   = scl;
            want.sda_release = sda;
            want.busy_res    = busy();
            want.done_res    = done_now;
            want.read_byte   = shifter;
            want.nack_seen   = ack_flag;
            expected_results.push_back(want);
            return effect;
        endfunction

        function void check_result(logic [15:0] word);
            seq_result_t got;
            seq_result_t want;
            string       bad;
            got = seq_result_t'(word[12:0]);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result %h with no request outstanding", $realtime, word);
                return;
            end
            want = expected_results.pop_front();
            bad = "";
            if (got.scl_level   !== want.scl_level)   bad = {bad, " scl_level"};
            if (got.sda_release !== want.sda_release) bad = {bad, " sda_release"};
            if (got.busy_res    !== want.busy_res)    bad = {bad, " busy_res"};
            if (got.done_res    !== want.done_res)    bad = {bad, " done_res"};
            if (got.read_byte   !== want.read_byte)   bad = {bad, " read_byte"};
            if (got.nack_seen   !== want.nack_seen)   bad = {bad, " nack_seen"};
            if (word[15:13]     !== 3'b000)           bad = {bad, " padding"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"[%0t] mismatch in%s: expected scl=%0b sda=%0b busy=%0b done=%0b",
                              " byte=%02h nack=%0b, got scl=%0b sda=%0b busy=%0b done=%0b",
                              " byte=%02h nack=%0b pad=%0b"},
                             $realtime, bad,
                             want.scl_level, want.sda_release, want.busy_res, want.done_res,
                             want.read_byte, want.nack_seen,
                             got.scl_level, got.sda_release, got.busy_res, got.done_res,
                             got.read_byte, got.nack_seen, word[15:13]);
            end
        endfunction
    endclass

    // Every input starts at a known value.
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = 16'd0;   // [7:0] data_byte, [8] send_ack, [9] sda_in, zero pad
    logic [2:0]  s_tuser     = 3'd0;    // [2:0] operation
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;               // [0] scl_level, [1] sda_release, [2] busy_res,
                                        // [3] done_res, [11:4] read_byte, [12] nack_seen

    sequencer_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int effective_requests = 0;   // requests that changed the sequencer state
    int cycle_count = 0;

    i2c_master_byte_sequencer_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Stall the result channel at random; the percentage follows the current idling mode.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every result on the edge where it is taken. All inputs change only through
    // nonblocking updates, so the values seen here are the ones the handshake used.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one request, hold it until taken, then feed it to the predictor.
    // Random gaps go in front of the request according to the sender idling mode.
    task automatic send_request(input logic [2:0] op, input logic [7:0] data,
                                input logic ack, input logic sda_in);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, sda_in, ack, data};
        do @(posedge aclk); while (!s_tready);
        if (sb.note_request(op, data, ack, sda_in)) effective_requests++;
    endtask

    // Tick the running command to its end with random SDA levels. With noise_pct above
    // zero, mix in commands given while busy and undefined codes, which must be ignored.
    task automatic tick_until_idle(input int noise_pct);
        while (sb.busy()) begin
            if ($urandom_range(99) < noise_pct)
                send_request(3'($urandom_range(OP_START, OP_BAD_HI)), 8'($urandom_range(255)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                send_request(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
        end
    endtask

    // Finish any running command, drain all results, then load a new phase length.
    task automatic load_phase_ticks(input logic [7:0] value);
        tick_until_idle(0);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_phase_ticks(value);
    endtask

    // Mostly complete commands with random content, with idle ticks and undefined
    // codes as noise, until enough requests have had an effect.
    task automatic run_random(input int budget);
        int stop_at;
        int pick;
        stop_at = effective_requests + budget;
        while (effective_requests < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                send_request(3'($urandom_range(OP_START, OP_READ)), 8'($urandom_range(255)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
                tick_until_idle(4);
            end else if (pick < 93) begin
                send_request(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            end else begin
                send_request(3'($urandom_range(OP_BAD_LO, OP_BAD_HI)), 8'($urandom_range(255)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles lightly, receiver stalls heavily.
        send_idle_pct  = 33;
        recv_stall_pct = 70;
        load_phase_ticks(8'd1);

        // Directed: idle tick, undefined code, start, a command while busy, repeated
        // start from low lines, and a write of all zeros with a pulled-low acknowledge.
        send_request(OP_TICK, 8'h00, 1'b0, 1'b1);
        send_request(OP_BAD_HI, 8'hFF, 1'b1, 1'b1);
        send_request(OP_START, 8'h00, 1'b0, 1'b0);
        send_request(OP_STOP, 8'hFF, 1'b1, 1'b0);
        tick_until_idle(0);
        send_request(OP_START, 8'h00, 1'b0, 1'b0);
        tick_until_idle(0);
        send_request(OP_WRITE, 8'h00, 1'b0, 1'b0);
        repeat (18) send_request(OP_TICK, 8'h00, 1'b0, 1'b0);

        run_random(160);
        load_phase_ticks(8'd2);
        run_random(80);

        // Swap the idling between the two sides.
        send_idle_pct  = 70;
        recv_stall_pct = 33;
        load_phase_ticks(8'd1);
        run_random(190);

        // No idling at all.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_phase_ticks(8'd3);
        run_random(240);

        // Longest phase: one start sequence runs out all 255 ticks per phase.
        load_phase_ticks(8'd255);
        send_request(OP_START, 8'($urandom_range(255)), 1'b0, 1'b0);
        tick_until_idle(0);

        // Drain outstanding results.
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/i2cmbs_pkg.sv
rtl/i2cmbs_step.sv
rtl/i2c_master_byte_sequencer_unit.sv
rtl/i2cmbs_checker.sv
test/i2c_master_byte_sequencer_unit_tb.sv
